/* rtl/dmf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types, codes and default sizes of the max-flow engine.
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int unsigned DEF_MAX_NODES = 128;
    localparam int unsigned DEF_MAX_ARCS  = 8192;
    localparam int unsigned DEF_CAP_BITS  = 16;

    localparam int unsigned NODE_W  = 7;
    localparam int unsigned CAPIN_W = 16;
    localparam int unsigned FLOW_W  = 28;

    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_RUN   = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;   // unused code, ignored

    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_SINK   = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [NODE_W-1:0]  from_node;
        logic [NODE_W-1:0]  to_node;
        logic [CAPIN_W-1:0] capacity;
    } t_in;

    typedef struct packed {
        logic [FLOW_W-1:0] flow_value;
        logic              status;
    } t_out;

endpackage
`default_nettype wire

/* rtl/dmf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dmf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dmf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/dinic_max_flow.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dinic_max_flow
// Dinic max-flow engine: arc store, level pass and stack-based blocking pass.
// ----------------------------------------------------------------------------
// A clear transaction and an add-edge transaction give no result. A run
// transaction keeps the block busy for a data-dependent time set by the
// memory walks: each level pass dequeues nodes and scans their arcs, and
// each blocking pass probes arcs, pushes frames and pops them, repeated
// until the sink is unreachable. The result then sits in an output register
// while edge loads and clears are taken again. The arc store, node tables,
// queue and stack are RAMs; list heads and levels carry valid bits, so a
// clear or a new level pass needs no sweep. The user must write source and
// sink on the config port only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module dinic_max_flow #(
    parameter int unsigned MAX_NODES = dmf_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_ARCS  = dmf_pkg::DEF_MAX_ARCS,
    parameter int unsigned CAP_BITS  = dmf_pkg::DEF_CAP_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire dmf_pkg::t_in               i_in_data,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      dmf_pkg::t_out              o_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_addr,
    input  wire logic [dmf_pkg::NODE_W-1:0] i_cfg_wdata
);

    // widths
    localparam int unsigned NB  = $clog2(MAX_NODES);      // node index
    localparam int unsigned AW  = $clog2(MAX_ARCS);       // arc index
    localparam int unsigned LW  = AW + 1;                 // arc link, all ones = end
    localparam int unsigned CW  = $clog2(MAX_ARCS + 1);   // arc count
    localparam int unsigned VW  = NB + 2;                 // level, two's complement
    localparam int unsigned QW  = $clog2(MAX_NODES + 1);  // queue pointers
    localparam int unsigned SPW = $clog2(MAX_NODES + 2);  // stack depth
    localparam int unsigned PW  = CAP_BITS + AW + 1;      // pushed flow
    localparam int unsigned FW  = dmf_pkg::FLOW_W;
    localparam int unsigned SW  = ((PW > FW) ? PW : FW) + 1;

    localparam logic [LW-1:0] ARC_END  = {LW{1'b1}};
    localparam logic [VW-1:0] LVL_NONE = {VW{1'b1}};
    localparam logic [VW-1:0] LVL_DEAD = {{(VW-1){1'b1}}, 1'b0};

    typedef struct packed {
        logic [NB-1:0] target;
        logic [LW-1:0] link;
    } t_arc;

    typedef struct packed {
        logic [NB-1:0]       node;
        logic [VW-1:0]       lvl;
        logic [LW-1:0]       arc;
        logic                unl;     // source frame: unlimited budget
        logic [CAP_BITS-1:0] avail;
        logic [PW-1:0]       pushed;
    } t_frame;

    typedef struct packed {
        logic [NB-1:0] node;
        logic [VW-1:0] lvl;
    } t_qent;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD0, S_ADD1, S_ADD2,
        S_LINIT, S_LPOP, S_LFA, S_LFB, S_LARC, S_LCHK,
        S_DINIT, S_DINIT2, S_DTOP, S_DARC, S_DCHK, S_DPUSH,
        S_DRET, S_DPOP, S_DR1, S_DR2, S_FIN
    } t_state;

    t_state r_state;

    logic [dmf_pkg::NODE_W-1:0] r_src, r_snk;
    logic [CW-1:0]        r_cnt;
    logic                 r_ovf;
    logic [MAX_NODES-1:0] r_first_vld;
    logic [MAX_NODES-1:0] r_lvl_vld;
    logic                 r_frd_vld, r_lrd_vld;
    logic [NB-1:0]        r_eu, r_ev;
    logic [CAP_BITS-1:0]  r_ecap;
    logic [QW-1:0]        r_head, r_tail;
    t_qent                r_cur;          // node being expanded in the level pass
    logic [NB-1:0]        r_v;
    logic [LW-1:0]        r_link;
    logic [CAP_BITS-1:0]  r_res;
    t_frame               r_top;
    logic [SPW-1:0]       r_sp;
    logic [PW-1:0]        r_ret;
    logic [FW-1:0]        r_total;
    logic                 r_out_valid;
    dmf_pkg::t_out        r_out;

    // memory ports
    logic            first_we;
    logic [NB-1:0]   first_waddr, first_raddr;
    logic [LW-1:0]   first_wdata, first_rdata;
    logic            arc_we;
    logic [AW-1:0]   arc_waddr, arc_raddr;
    t_arc            arc_wdata, arc_rdata;
    logic            res_we;
    logic [AW-1:0]   res_waddr, res_raddr;
    logic [CAP_BITS-1:0] res_wdata, res_rdata;
    logic            lvl_we;
    logic [NB-1:0]   lvl_waddr, lvl_raddr;
    logic [VW-1:0]   lvl_wdata, lvl_rdata;
    logic            q_we;
    logic [NB-1:0]   q_waddr, q_raddr;
    t_qent           q_wdata, q_rdata;
    logic            stk_we;
    logic [NB-1:0]   stk_waddr, stk_raddr;
    t_frame          stk_wdata, stk_rdata;

    dmf_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_waddr(first_waddr), .i_wdata(first_wdata),
        .i_raddr(first_raddr), .o_rdata(first_rdata));
    dmf_ram #(.WIDTH($bits(t_arc)), .DEPTH(MAX_ARCS)) u_arc (
        .i_clk(i_clk), .i_we(arc_we), .i_waddr(arc_waddr), .i_wdata(arc_wdata),
        .i_raddr(arc_raddr), .o_rdata(arc_rdata));
    dmf_ram #(.WIDTH(CAP_BITS), .DEPTH(MAX_ARCS)) u_res (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_waddr), .i_wdata(res_wdata),
        .i_raddr(res_raddr), .o_rdata(res_rdata));
    dmf_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_lvl (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wdata),
        .i_raddr(lvl_raddr), .o_rdata(lvl_rdata));
    dmf_ram #(.WIDTH($bits(t_qent)), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));
    dmf_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_NODES)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata));

    // derived values
    logic [NB-1:0]       src_n, snk_n, in_u, in_v;
    logic                in_range, run_bad;
    logic [LW-1:0]       fval, fv, cnt_l, c0, c1;
    logic [CW:0]         cnt_p2;
    logic [VW-1:0]       lv;
    logic [SPW-1:0]      sp_m1, sp_m2;
    logic                push_ok;
    logic [CAP_BITS-1:0] push_avail;
    logic [CAP_BITS-1:0] ret_c;
    logic [CAP_BITS-1:0] dr_avail;
    logic [PW-1:0]       dr_pushed;
    logic [SW-1:0]       sum;
    logic                in_acc;

    assign src_n    = NB'(r_src);
    assign snk_n    = NB'(r_snk);
    assign in_u     = NB'(i_in_data.from_node);
    assign in_v     = NB'(i_in_data.to_node);
    assign in_range = (32'(i_in_data.from_node) < MAX_NODES)
                   && (32'(i_in_data.to_node) < MAX_NODES);
    assign run_bad  = (32'(r_src) >= MAX_NODES) || (32'(r_snk) >= MAX_NODES)
                   || (r_src == r_snk);
    assign cnt_l    = LW'(r_cnt);
    assign c0       = cnt_l;
    assign c1       = cnt_l + LW'(1);
    assign cnt_p2   = (CW+1)'(r_cnt) + (CW+1)'(2);
    assign fval     = r_frd_vld ? first_rdata : ARC_END;
    // self loop: second list head is the arc just written
    assign fv       = (r_eu == r_ev) ? c0 : fval;
    assign lv       = r_lrd_vld ? lvl_rdata : LVL_NONE;
    assign sp_m1    = r_sp - SPW'(1);
    assign sp_m2    = r_sp - SPW'(2);
    assign push_ok  = (lv == (r_top.lvl + VW'(1))) && (r_res != '0)
                   && (32'(r_sp) <= MAX_NODES);
    assign push_avail = (r_top.unl || (r_res < r_top.avail)) ? r_res : r_top.avail;
    assign ret_c    = CAP_BITS'(r_ret);
    assign dr_avail = r_top.avail - ret_c;
    assign dr_pushed = r_top.pushed + r_ret;
    assign sum      = SW'(r_total) + SW'(r_ret);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // memory control
    always_comb begin
        first_we = 1'b0; first_waddr = r_eu; first_wdata = c0; first_raddr = '0;
        arc_we = 1'b0; arc_waddr = c0[AW-1:0]; arc_wdata = '{target: r_ev, link: fval};
        arc_raddr = '0;
        res_we = 1'b0; res_waddr = c0[AW-1:0]; res_wdata = r_ecap; res_raddr = '0;
        lvl_we = 1'b0; lvl_waddr = src_n; lvl_wdata = '0; lvl_raddr = arc_rdata.target;
        q_we = 1'b0; q_waddr = r_tail[NB-1:0]; q_wdata = '{node: r_v, lvl: r_cur.lvl + VW'(1)};
        q_raddr = r_head[NB-1:0];
        stk_we = 1'b0; stk_waddr = sp_m1[NB-1:0]; stk_wdata = r_top;
        stk_raddr = sp_m2[NB-1:0];
        unique case (r_state)
            S_ADD0: begin
                first_raddr = r_eu;
            end
            S_ADD1: begin
                first_we    = 1'b1;
                arc_we      = 1'b1;
                res_we      = 1'b1;
                first_raddr = r_ev;
            end
            S_ADD2: begin
                first_we    = 1'b1;
                first_waddr = r_ev;
                first_wdata = c1;
                arc_we      = 1'b1;
                arc_waddr   = c1[AW-1:0];
                arc_wdata   = '{target: r_eu, link: fv};
                res_we      = 1'b1;
                res_waddr   = c1[AW-1:0];
                res_wdata   = '0;
            end
            S_LINIT: begin
                lvl_we  = 1'b1;
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '{node: src_n, lvl: '0};
            end
            S_LFA: begin
                first_raddr = q_rdata.node;
            end
            S_LFB: begin
                arc_raddr = fval[AW-1:0];
                res_raddr = fval[AW-1:0];
            end
            S_LCHK: begin
                if ((lv == LVL_NONE) && (r_res != '0)) begin
                    lvl_we    = 1'b1;
                    lvl_waddr = r_v;
                    lvl_wdata = r_cur.lvl + VW'(1);
                    q_we      = (32'(r_tail) < MAX_NODES);
                end
                arc_raddr = r_link[AW-1:0];
                res_raddr = r_link[AW-1:0];
            end
            S_DINIT: begin
                first_raddr = src_n;
            end
            S_DTOP: begin
                arc_raddr = r_top.arc[AW-1:0];
                res_raddr = r_top.arc[AW-1:0];
                if ((r_top.node != snk_n) && !(r_top.arc < cnt_l)
                        && (r_top.pushed == '0)) begin
                    lvl_we    = 1'b1;
                    lvl_waddr = r_top.node;
                    lvl_wdata = LVL_DEAD;
                end
            end
            S_DCHK: begin
                first_raddr = r_v;
                stk_we      = push_ok;
            end
            S_DPOP: begin
                arc_raddr = stk_rdata.arc[AW-1:0];
                res_raddr = stk_rdata.arc[AW-1:0];
            end
            S_DR1: begin
                res_we    = 1'b1;
                res_waddr = r_top.arc[AW-1:0];
                res_wdata = res_rdata - ret_c;
                res_raddr = {r_top.arc[AW-1:1], ~r_top.arc[0]};
            end
            S_DR2: begin
                res_we    = 1'b1;
                res_waddr = {r_top.arc[AW-1:1], ~r_top.arc[0]};
                res_wdata = res_rdata + ret_c;
                if (!r_top.unl && (dr_avail == '0) && (dr_pushed == '0)) begin
                    lvl_we    = 1'b1;
                    lvl_waddr = r_top.node;
                    lvl_wdata = LVL_DEAD;
                end
            end
            default: begin
            end
        endcase
    end

    // control, registers and outputs
    always_ff @(posedge i_clk) begin
        r_frd_vld <= r_first_vld[first_raddr];
        r_lrd_vld <= r_lvl_vld[lvl_raddr];

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_src       <= '0;
            r_snk       <= dmf_pkg::NODE_W'(1);
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_first_vld <= '0;
            r_lvl_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == dmf_pkg::CFG_SOURCE) begin
                    r_src <= i_cfg_wdata;
                end else begin
                    r_snk <= i_cfg_wdata;
                end
            end
            // the final state reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (first_we) begin
                r_first_vld[first_waddr] <= 1'b1;
            end
            // a new level pass restarts the valid bits itself
            if (lvl_we && (r_state != S_LINIT)) begin
                r_lvl_vld[lvl_waddr] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        priority case (i_in_data.func)
                            dmf_pkg::FUNC_CLEAR: begin
                                r_cnt       <= '0;
                                r_ovf       <= 1'b0;
                                r_first_vld <= '0;
                            end
                            dmf_pkg::FUNC_ADD: begin
                                if (in_range) begin
                                    if (32'(cnt_p2) > MAX_ARCS) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_eu    <= in_u;
                                        r_ev    <= in_v;
                                        r_ecap  <= CAP_BITS'(i_in_data.capacity);
                                        r_state <= S_ADD0;
                                    end
                                end
                            end
                            dmf_pkg::FUNC_RUN: begin
                                r_total <= '0;
                                r_state <= run_bad ? S_FIN : S_LINIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADD0: r_state <= S_ADD1;
                S_ADD1: r_state <= S_ADD2;
                S_ADD2: begin
                    r_cnt   <= CW'(cnt_p2);
                    r_state <= S_IDLE;
                end
                S_LINIT: begin
                    r_lvl_vld <= MAX_NODES'(1) << src_n;
                    r_head    <= '0;
                    r_tail    <= QW'(1);
                    r_state   <= S_LPOP;
                end
                S_LPOP: begin
                    if (r_head != r_tail) begin
                        r_head  <= r_head + QW'(1);
                        r_state <= S_LFA;
                    end else begin
                        r_state <= r_lvl_vld[snk_n] ? S_DINIT : S_FIN;
                    end
                end
                S_LFA: begin
                    r_cur   <= q_rdata;
                    r_state <= S_LFB;
                end
                S_LFB: begin
                    r_state <= (fval < cnt_l) ? S_LARC : S_LPOP;
                end
                S_LARC: begin
                    r_v     <= arc_rdata.target;
                    r_link  <= arc_rdata.link;
                    r_res   <= res_rdata;
                    r_state <= S_LCHK;
                end
                S_LCHK: begin
                    if (q_we) begin
                        r_tail <= r_tail + QW'(1);
                    end
                    r_state <= (r_link < cnt_l) ? S_LARC : S_LPOP;
                end
                S_DINIT: begin
                    r_top.node   <= src_n;
                    r_top.lvl    <= '0;
                    r_top.unl    <= 1'b1;
                    r_top.avail  <= '0;
                    r_top.pushed <= '0;
                    r_sp         <= SPW'(1);
                    r_state      <= S_DINIT2;
                end
                S_DINIT2: begin
                    r_top.arc <= fval;
                    r_state   <= S_DTOP;
                end
                S_DTOP: begin
                    priority if (r_top.node == snk_n) begin
                        r_ret   <= PW'(r_top.avail);
                        r_state <= S_DRET;
                    end else if (r_top.arc < cnt_l) begin
                        r_state <= S_DARC;
                    end else begin
                        r_ret   <= r_top.pushed;
                        r_state <= S_DRET;
                    end
                end
                S_DARC: begin
                    r_v     <= arc_rdata.target;
                    r_link  <= arc_rdata.link;
                    r_res   <= res_rdata;
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    if (push_ok) begin
                        r_top.node   <= r_v;
                        r_top.lvl    <= lv;
                        r_top.unl    <= 1'b0;
                        r_top.avail  <= push_avail;
                        r_top.pushed <= '0;
                        r_sp         <= r_sp + SPW'(1);
                        r_state      <= S_DPUSH;
                    end else begin
                        r_top.arc <= r_link;
                        r_state   <= S_DTOP;
                    end
                end
                S_DPUSH: begin
                    r_top.arc <= fval;
                    r_state   <= S_DTOP;
                end
                S_DRET: begin
                    if (r_sp == SPW'(1)) begin
                        // source frame done: pass total, saturating
                        r_total <= (sum > SW'(dmf_pkg::FLOW_MAX)) ? dmf_pkg::FLOW_MAX
                                                                 : FW'(sum);
                        r_state <= S_LINIT;
                    end else begin
                        r_sp    <= sp_m1;
                        r_state <= S_DPOP;
                    end
                end
                S_DPOP: begin
                    r_top   <= stk_rdata;
                    r_state <= S_DR1;
                end
                S_DR1: begin
                    r_link  <= arc_rdata.link;
                    r_state <= S_DR2;
                end
                S_DR2: begin
                    r_top.pushed <= dr_pushed;
                    if (!r_top.unl) begin
                        r_top.avail <= dr_avail;
                    end
                    if (!r_top.unl && (dr_avail == '0)) begin
                        r_ret   <= dr_pushed;
                        r_state <= S_DRET;
                    end else begin
                        r_top.arc <= r_link;
                        r_state   <= S_DTOP;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.flow_value <= r_total;
                        r_out.status     <= r_ovf;
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
